@@ rtl/sgtc_pkg.sv @@
// ----------------------------------------------------------------------------
// sgtc_pkg
// Shared constants, job descriptor type and grid sizing for the square grid
// transposition cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgtc_pkg;

  // Message store size and derived widths
  localparam int MAX_LEN  = 64;
  localparam int IDX_W    = $clog2(MAX_LEN);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  // Two banks: one loads while the other is read out
  localparam int RAM_AW   = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;
  localparam int BYTE_W   = 8;

  // Grid side is at most 8 for messages up to 64 bytes
  localparam int GRID_MAX = 8;
  localparam int GRID_W   = 4;
  localparam int POS_W    = 2 * GRID_W - 1;

  // Register indexes and mode codes
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_PAD_CHAR  = 1'b1;
  localparam logic DIR_ENCRYPT   = 1'b0;
  localparam logic DIR_DECRYPT   = 1'b1;
  localparam logic [BYTE_W-1:0] PAD_RESET = 8'd96;

  typedef struct packed {
    logic [GRID_W-1:0] rows;
    logic [GRID_W-1:0] cols;
  } grid_t;

  // One message ready for read-out
  typedef struct packed {
    logic              bank;
    logic [CNT_W-1:0]  len;
    grid_t             grid;
    logic              dir;
    logic [BYTE_W-1:0] pad;
  } job_t;

  // rows = isqrt(len); cols = rows or rows+1; rows+1 if still too small
  function automatic grid_t grid_size(logic [CNT_W-1:0] len);
    logic [GRID_W-1:0]   r;
    logic [GRID_W-1:0]   c;
    logic [2*GRID_W-1:0] sq;
    logic [2*GRID_W-1:0] area;
    grid_t               g;
    r = '0;
    for (int k = 1; k <= GRID_MAX; k++) begin
      if (k * k <= int'(len)) r = GRID_W'(k);
    end
    sq   = r * r;
    c    = (int'(sq) == int'(len)) ? r : GRID_W'(r + 1'b1);
    area = r * c;
    if (int'(area) < int'(len)) r = GRID_W'(r + 1'b1);
    g.rows = r;
    g.cols = c;
    return g;
  endfunction

endpackage

@@ rtl/sgtc_ram.sv @@
// ----------------------------------------------------------------------------
// sgtc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/sgtc_front.sv @@
// ----------------------------------------------------------------------------
// sgtc_front
// Loads message bytes into the current bank, holds the configuration and
// hands each finished message to the job queue with its grid size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgtc_front import sgtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [BYTE_W-1:0] in_msg_byte,
  input  logic              in_msg_last,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic [1:0]        q_cnt,
  input  logic              back_active,
  output logic              busy,
  output logic              ram_we,
  output logic [RAM_AW-1:0] ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic              push,
  output job_t              push_job
);

  logic              dir_r, dir_nxt;
  logic [BYTE_W-1:0] pad_r, pad_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              bank_r, bank_nxt;
  logic              accept;
  logic              room;
  logic [CNT_W-1:0]  len_new;
  logic [2:0]        outstanding;

  // Both banks in use: one queued or being read, the other waiting
  assign outstanding = {1'b0, q_cnt} + {2'b00, back_active};
  assign busy        = (outstanding >= 3'd2);
  assign accept      = start && !busy;

  // Store write; bytes past the end of the store are dropped
  assign room      = (int'(count_r) < MAX_LEN);
  assign ram_we    = accept && room;
  assign ram_waddr = {bank_r, count_r[IDX_W-1:0]};
  assign ram_wdata = in_msg_byte;
  assign len_new   = room ? CNT_W'(count_r + 1'b1) : count_r;

  // Job request at end of message
  assign push          = accept && in_msg_last;
  assign push_job.bank = bank_r;
  assign push_job.len  = len_new;
  assign push_job.grid = grid_size(len_new);
  assign push_job.dir  = dir_r;
  assign push_job.pad  = pad_r;

  always_comb begin
    dir_nxt   = dir_r;
    pad_nxt   = pad_r;
    count_nxt = count_r;
    bank_nxt  = bank_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION: dir_nxt = cfg_wdata[0];
        REG_PAD_CHAR:  pad_nxt = cfg_wdata;
        default:       dir_nxt = dir_r;
      endcase
    end
    if (accept) begin
      if (in_msg_last) begin
        count_nxt = '0;
        bank_nxt  = !bank_r;
      end else begin
        count_nxt = len_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_ENCRYPT;
      pad_r   <= PAD_RESET;
      count_r <= '0;
      bank_r  <= 1'b0;
    end else begin
      dir_r   <= dir_nxt;
      pad_r   <= pad_nxt;
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

@@ rtl/sgtc_job_fifo.sv @@
// ----------------------------------------------------------------------------
// sgtc_job_fifo
// Two-entry queue of message jobs between loader and read-out sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgtc_job_fifo import sgtc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       head,
  output logic       not_empty,
  output logic [1:0] cnt
);

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head      = slot_r[rd_ptr_r];
  assign not_empty = (cnt_r != 2'd0);
  assign cnt       = cnt_r;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/sgtc_back.sv @@
// ----------------------------------------------------------------------------
// sgtc_back
// Walks the grid of one job a cell per cycle, reads the store, drops padding
// on decrypt and drives the result strobe with the end-of-message flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgtc_back import sgtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  job_t              head,
  input  logic              not_empty,
  output logic              pop,
  output logic              active,
  output logic [RAM_AW-1:0] ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  // Sequencer state
  logic              active_r, active_nxt;
  job_t              job_r, job_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [GRID_W-1:0] inner_r, inner_nxt;
  logic [GRID_W-1:0] outer_r, outer_nxt;

  logic [GRID_W-1:0] stride;
  logic [GRID_W-1:0] n_inner;
  logic [GRID_W-1:0] n_outer;
  logic              inner_end;
  logic              last_cell;
  logic              in_range;

  // Read stage
  logic              s1_v_r;
  logic              s1_in_range_r;
  logic              s1_end_r;
  logic              s1_dir_r;
  logic [BYTE_W-1:0] s1_pad_r;

  // Hold stage and output
  logic              hold_v_r, hold_v_nxt;
  logic [BYTE_W-1:0] hold_byte_r, hold_byte_nxt;
  logic              flush_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic [BYTE_W-1:0] cell_byte;
  logic              keep;

  // Encrypt walks columns (stride cols), decrypt walks rows (stride rows)
  assign stride  = (job_r.dir == DIR_DECRYPT) ? job_r.grid.rows : job_r.grid.cols;
  assign n_inner = (job_r.dir == DIR_DECRYPT) ? job_r.grid.cols : job_r.grid.rows;
  assign n_outer = (job_r.dir == DIR_DECRYPT) ? job_r.grid.rows : job_r.grid.cols;

  assign inner_end = (inner_r == GRID_W'(n_inner - 1'b1));
  assign last_cell = active_r && inner_end && (outer_r == GRID_W'(n_outer - 1'b1));
  assign in_range  = (int'(pos_r) < int'(job_r.len));
  assign ram_raddr = {job_r.bank, pos_r[IDX_W-1:0]};
  assign pop       = not_empty && (!active_r || last_cell);
  assign active    = active_r;

  // Cell address sequencer
  always_comb begin
    active_nxt = active_r;
    job_nxt    = job_r;
    pos_nxt    = pos_r;
    inner_nxt  = inner_r;
    outer_nxt  = outer_r;
    if (active_r) begin
      if (inner_end) begin
        inner_nxt = '0;
        outer_nxt = GRID_W'(outer_r + 1'b1);
        pos_nxt   = POS_W'(outer_r) + POS_W'(1);
      end else begin
        inner_nxt = GRID_W'(inner_r + 1'b1);
        pos_nxt   = pos_r + POS_W'(stride);
      end
      if (last_cell) active_nxt = 1'b0;
    end
    if (pop) begin
      active_nxt = 1'b1;
      job_nxt    = head;
      pos_nxt    = '0;
      inner_nxt  = '0;
      outer_nxt  = '0;
    end
  end

  // Cell value: stored byte inside the message, pad beyond it
  assign cell_byte = s1_in_range_r ? ram_rdata : s1_pad_r;
  assign keep      = s1_v_r && ((s1_dir_r == DIR_ENCRYPT) || (cell_byte != s1_pad_r));

  // One kept byte is held back so the final one can carry the last flag
  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_byte_nxt = hold_byte_r;
    out_valid_nxt = 1'b0;
    out_byte_nxt  = hold_byte_r;
    out_last_nxt  = 1'b0;
    if (flush_r) begin
      out_valid_nxt = hold_v_r;
      out_last_nxt  = 1'b1;
      hold_v_nxt    = 1'b0;
    end else if (keep) begin
      out_valid_nxt = hold_v_r;
    end
    if (keep) begin
      hold_v_nxt    = 1'b1;
      hold_byte_nxt = cell_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      s1_v_r      <= 1'b0;
      s1_end_r    <= 1'b0;
      hold_v_r    <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      s1_v_r      <= active_r;
      s1_end_r    <= last_cell;
      hold_v_r    <= hold_v_nxt;
      flush_r     <= s1_v_r && s1_end_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_r         <= job_nxt;
    pos_r         <= pos_nxt;
    inner_r       <= inner_nxt;
    outer_r       <= outer_nxt;
    s1_in_range_r <= in_range;
    s1_dir_r      <= job_r.dir;
    s1_pad_r      <= job_r.pad;
    hold_byte_r   <= hold_byte_nxt;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/square_grid_transposition_cipher.sv @@
// ----------------------------------------------------------------------------
// square_grid_transposition_cipher
// Columnar transposition over a near-square grid: loads a message, then
// reads it out column-major (encrypt) or row-major without padding (decrypt).
//
//   channel | ports                                  | flow
//   --------+----------------------------------------+------------------------
//   input   | start, busy, in_msg_byte, in_msg_last  | taken when start & !busy
//   result  | out_valid, out_byte, out_last          | one-cycle strobe
//   config  | cfg_we, cfg_index, cfg_wdata           | write when cfg_we
//
// A byte is taken when start & !busy. After the last byte, the read-out
// sequencer visits rows*cols grid cells at one per cycle (one store read port);
// results trail the walk through the store read, hold and output registers,
// later on decrypt while skipped padding lies between kept bytes. The store
// has two banks, so the next message loads while the previous one is read out;
// busy rises when both banks hold unread messages. Reset is synchronous; the
// store needs no clearing pass. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module square_grid_transposition_cipher import sgtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [BYTE_W-1:0] in_msg_byte,
  input  logic              in_msg_last,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata
);

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              push;
  job_t              push_job;
  logic              pop;
  job_t              head;
  logic              not_empty;
  logic [1:0]        q_cnt;
  logic              back_active;

  // Loader and configuration
  sgtc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_msg_byte (in_msg_byte),
    .in_msg_last (in_msg_last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_cnt       (q_cnt),
    .back_active (back_active),
    .busy        (busy),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .push        (push),
    .push_job    (push_job)
  );

  // Message store, two banks
  sgtc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Job queue
  sgtc_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .cnt       (q_cnt)
  );

  // Read-out sequencer
  sgtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .active    (back_active),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the square grid transposition cipher. A clocked
// driver feeds message bytes from a request queue and a clocked monitor
// predicts the cipher output for every accepted request and compares each
// output strobe, byte and last flag against the oldest predicted character.
// Directed messages cover the small grids, padding and the empty decrypt
// case, then randomized phases sweep both directions and several pad values
// with varying sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sgtc_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 30;

  typedef struct {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } char_rec_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [BYTE_W-1:0] in_msg_byte = '0;
  logic              in_msg_last = 1'b0;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              cfg_we      = 1'b0;
  logic              cfg_index   = REG_DIRECTION;
  logic [BYTE_W-1:0] cfg_wdata   = '0;

  // Request queue, predicted output and bookkeeping
  char_rec_t   msg_requests[$];
  char_rec_t   expected_chars[$];
  int          send_idle_pct  = 0;
  int          requests_queued = 0;
  int          requests_taken  = 0;
  int          mismatches      = 0;
  int          quiet_cycles    = 0;

  // Predictor state: message buffer and shadow registers
  logic [BYTE_W-1:0] msg_mem [MAX_LEN];
  int unsigned       msg_len = 0;
  logic              dir_q   = DIR_ENCRYPT;
  logic [BYTE_W-1:0] pad_q   = PAD_RESET;

  square_grid_transposition_cipher dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_msg_byte (in_msg_byte),
    .in_msg_last (in_msg_last),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cell of the grid at a linear position; cells past the message are padding
  function automatic logic [BYTE_W-1:0] grid_cell(int unsigned pos, int unsigned len);
    return (pos < len) ? msg_mem[pos] : pad_q;
  endfunction

  // Store one byte; on the last byte, size the grid and queue the cipher text
  task automatic predict_cipher(input logic [BYTE_W-1:0] ch, input logic last);
    int unsigned       len;
    int unsigned       rows;
    int unsigned       cols;
    logic [BYTE_W-1:0] grid_byte;
    logic [BYTE_W-1:0] burst[$];
    if (msg_len < MAX_LEN) begin
      msg_mem[msg_len] = ch;
      msg_len++;
    end
    if (last) begin
      len     = msg_len;
      msg_len = 0;
      rows    = 0;
      while ((rows + 1) * (rows + 1) <= len) rows++;
      cols = (rows * rows == len) ? rows : rows + 1;
      if (rows * cols < len) rows++;
      if (dir_q == DIR_ENCRYPT) begin
        // fill row-major, read column-major, padding included
        for (int c = 0; c < cols; c++)
          for (int r = 0; r < rows; r++)
            burst.push_back(grid_cell(r * cols + c, len));
      end else begin
        // fill column-major, read row-major, padding dropped
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++) begin
            grid_byte = grid_cell(c * rows + r, len);
            if (grid_byte != pad_q) burst.push_back(grid_byte);
          end
      end
      foreach (burst[i])
        expected_chars.push_back('{burst[i], i == burst.size() - 1});
    end
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ERROR: %s", $realtime, msg);
  endtask

  // Driver: offer the next queued byte, with random gaps between requests
  always @(posedge clk) begin
    char_rec_t item;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (msg_requests.size() == 0 || $urandom_range(99) < send_idle_pct) begin
        start <= 1'b0;
      end else begin
        item        = msg_requests.pop_front();
        start       <= 1'b1;
        in_msg_byte <= item.ch;
        in_msg_last <= item.last;
      end
    end
  end

  // Monitor: track register writes, predict on accepted requests, check output
  always @(posedge clk) begin
    char_rec_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == REG_DIRECTION) dir_q = cfg_wdata[0];
        else                            pad_q = cfg_wdata;
      end
      if (start && !busy) begin
        predict_cipher(in_msg_byte, in_msg_last);
        requests_taken++;
      end
      if (out_valid) begin
        if (expected_chars.size() == 0) begin
          log_mismatch($sformatf("unexpected output byte %h last %b", out_byte, out_last));
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want.ch || out_last !== want.last)
            log_mismatch($sformatf("byte exp %h got %h, last exp %b got %b",
                                   want.ch, out_byte, want.last, out_last));
        end
      end
    end
  end

  // Watchdog: no request, output or register write for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [BYTE_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic queue_char(input logic [BYTE_W-1:0] ch, input logic last);
    msg_requests.push_back('{ch, last});
    requests_queued++;
  endtask

  // Random message; about one byte in eight equals the pad character
  task automatic queue_random_msg(input int len, input logic [BYTE_W-1:0] pad);
    logic [BYTE_W-1:0] ch;
    for (int i = 0; i < len; i++) begin
      ch = ($urandom_range(7) == 0) ? pad : BYTE_W'($urandom_range(255));
      queue_char(ch, i == len - 1);
    end
  endtask

  // Wait until every request is taken and all output has come, then let
  // the read-out sequencer finish any message that produced nothing
  task automatic settle();
    while (requests_taken != requests_queued) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                queued;
    int                len;
    int                pick;
    logic [BYTE_W-1:0] pad;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: encrypt, default pad. 1x1, 1x2 and padded 2x2 grids.
    queue_char(8'h00, 1'b1);
    queue_char(8'hFF, 1'b0);
    queue_char(PAD_RESET, 1'b1);
    queue_char(8'h01, 1'b0);
    queue_char(8'h02, 1'b0);
    queue_char(8'h03, 1'b1);
    settle();

    // Decrypt: lone pad byte gives nothing; pad inside message is dropped
    write_reg(REG_DIRECTION, BYTE_W'(DIR_DECRYPT));
    write_reg(REG_PAD_CHAR, 8'h2A);
    queue_char(8'h2A, 1'b1);
    queue_char(8'h41, 1'b0);
    queue_char(8'h2A, 1'b0);
    queue_char(8'h42, 1'b0);
    queue_char(8'h43, 1'b0);
    queue_char(8'h44, 1'b1);
    settle();

    // Decrypt with zero pad, extreme byte values
    write_reg(REG_PAD_CHAR, 8'h00);
    queue_char(8'h00, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h80, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h01, 1'b1);
    settle();

    // Random phases across direction, pad value and sender idle rate
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 3)
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 64;
        default: send_idle_pct = 28;
      endcase
      case (p)
        0:       pad = 8'h00;
        1:       pad = 8'hFF;
        2, 3:    pad = PAD_RESET;
        default: pad = BYTE_W'($urandom_range(255));
      endcase
      write_reg(REG_DIRECTION, BYTE_W'((p % 2 == 1) ? DIR_DECRYPT : DIR_ENCRYPT));
      write_reg(REG_PAD_CHAR, pad);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        // mostly short messages, some full 8x8, a few overflowing the store
        pick = $urandom_range(99);
        if (pick < 70)      len = $urandom_range(1, 16);
        else if (pick < 90) len = $urandom_range(17, 63);
        else if (pick < 95) len = MAX_LEN;
        else                len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
        queue_random_msg(len, pad);
        queued += len;
      end
      settle();
    end

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
